// File: hdl/z80_accumulator_flag_unit_assert.svh
// Assertion macros shared by the accumulator and flag unit.
`ifndef Z80_ACCUMULATOR_FLAG_UNIT_ASSERT_SVH
`define Z80_ACCUMULATOR_FLAG_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define Z80AF_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("z80af: same-cycle check failed");

// Next-cycle implication, disabled while reset is low.
`define Z80AF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("z80af: next-cycle check failed");

`endif

// File: hdl/z80af_pkg.sv
package z80af_pkg;

    // Operation codes carried by an item
    typedef enum logic [4:0] {
        OP_ADD   = 5'd0,
        OP_ADC   = 5'd1,
        OP_SUB   = 5'd2,
        OP_SBC   = 5'd3,
        OP_AND   = 5'd4,
        OP_XOR   = 5'd5,
        OP_OR    = 5'd6,
        OP_CP    = 5'd7,
        OP_RLCA  = 5'd8,
        OP_RRCA  = 5'd9,
        OP_RLA   = 5'd10,
        OP_RRA   = 5'd11,
        OP_DAA   = 5'd12,
        OP_CPL   = 5'd13,
        OP_SCF   = 5'd14,
        OP_CCF   = 5'd15,
        OP_NEG   = 5'd16,
        OP_LOADA = 5'd17,
        OP_LOADF = 5'd18
    } t_op;

    // Flag bit positions, as packed by PUSH AF
    localparam int unsigned FLAG_S  = 7;
    localparam int unsigned FLAG_Z  = 6;
    localparam int unsigned FLAG_U5 = 5;
    localparam int unsigned FLAG_H  = 4;
    localparam int unsigned FLAG_U3 = 3;
    localparam int unsigned FLAG_PV = 2;
    localparam int unsigned FLAG_N  = 1;
    localparam int unsigned FLAG_C  = 0;

    // Decimal adjust constants
    localparam logic [7:0] DAA_LIMIT  = 8'h99;
    localparam logic [7:0] DAA_CORR_H = 8'h60;
    localparam logic [7:0] DAA_CORR_L = 8'h06;
    localparam logic [3:0] DAA_NIB_MAX = 4'h9;

    // Architectural state: accumulator and flag byte
    typedef struct packed {
        logic [7:0] acc;
        logic [7:0] flags;
    } t_af;

endpackage

// File: hdl/z80af_alu.sv
module z80af_alu import z80af_pkg::*; (
    input  t_af        i_cur,
    input  logic [4:0] i_op,
    input  logic [7:0] i_operand,
    output t_af        o_nxt
);

    // Add with carry in; returns {flags, result}
    function automatic logic [15:0] f_add(input logic [7:0] a, input logic [7:0] b,
                                          input logic cin);
        logic [8:0] sum;
        logic [4:0] half;
        logic [7:0] r;
        logic [7:0] f;
        sum  = {1'b0, a} + {1'b0, b} + {8'd0, cin};
        half = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, cin};
        r    = sum[7:0];
        f    = {r[7], (r == 8'd0), r[5], half[4], r[3],
                ((a[7] ^ r[7]) & (b[7] ^ r[7])), 1'b0, sum[8]};
        return {f, r};
    endfunction

    // Subtract with borrow in; returns {flags, result}
    function automatic logic [15:0] f_sub(input logic [7:0] a, input logic [7:0] b,
                                          input logic cin);
        logic [8:0] diff;
        logic [4:0] half;
        logic [7:0] r;
        logic [7:0] f;
        diff = {1'b0, a} - {1'b0, b} - {8'd0, cin};
        half = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, cin};
        r    = diff[7:0];
        f    = {r[7], (r == 8'd0), r[5], half[4], r[3],
                ((a[7] ^ b[7]) & (a[7] ^ r[7])), 1'b1, diff[8]};
        return {f, r};
    endfunction

    // Flags of a logic op: sign, zero, copies, even parity
    function automatic logic [7:0] f_logic(input logic [7:0] r, input logic h);
        return {r[7], (r == 8'd0), r[5], h, r[3], ~^r, 1'b0, 1'b0};
    endfunction

    logic [7:0]  a;
    logic [7:0]  f;
    logic [7:0]  v;
    logic        c;
    logic [15:0] add_res;
    logic [15:0] sub_res;
    logic [15:0] neg_res;
    logic [7:0]  daa_corr;
    logic        daa_c;
    logic [7:0]  daa_r;
    logic [7:0]  r;
    logic [7:0]  nf;

    assign a = i_cur.acc;
    assign f = i_cur.flags;
    assign v = i_operand;
    assign c = f[FLAG_C];

    // Share one adder and one subtractor across add, subtract and compare; NEG uses a second subtractor
    always_comb begin
        add_res = f_add(a, v, (t_op'(i_op) == OP_ADC) ? c : 1'b0);
        sub_res = f_sub(a, v, (t_op'(i_op) == OP_SBC) ? c : 1'b0);
        neg_res = f_sub(8'd0, a, 1'b0);
    end

    // Decimal adjust correction
    always_comb begin
        daa_corr = 8'd0;
        daa_c    = c;
        if (f[FLAG_H] || (a[3:0] > DAA_NIB_MAX)) begin
            daa_corr = daa_corr | DAA_CORR_L;
        end
        if (c || (a > DAA_LIMIT)) begin
            daa_corr = daa_corr | DAA_CORR_H;
            daa_c    = 1'b1;
        end
        daa_r = f[FLAG_N] ? (a - daa_corr) : (a + daa_corr);
    end

    // Select result and flags per operation
    always_comb begin
        r  = a;
        nf = f;
        case (t_op'(i_op))
            OP_ADD, OP_ADC: begin
                r  = add_res[7:0];
                nf = add_res[15:8];
            end
            OP_SUB, OP_SBC: begin
                r  = sub_res[7:0];
                nf = sub_res[15:8];
            end
            OP_AND: begin
                r  = a & v;
                nf = f_logic(a & v, 1'b1);
            end
            OP_XOR: begin
                r  = a ^ v;
                nf = f_logic(a ^ v, 1'b0);
            end
            OP_OR: begin
                r  = a | v;
                nf = f_logic(a | v, 1'b0);
            end
            OP_CP: begin
                nf          = sub_res[15:8];
                nf[FLAG_U5] = v[5];
                nf[FLAG_U3] = v[3];
            end
            OP_RLCA: begin
                r  = {a[6:0], a[7]};
                nf = {f[7:6], r[5], 1'b0, r[3], f[FLAG_PV], 1'b0, a[7]};
            end
            OP_RRCA: begin
                r  = {a[0], a[7:1]};
                nf = {f[7:6], r[5], 1'b0, r[3], f[FLAG_PV], 1'b0, a[0]};
            end
            OP_RLA: begin
                r  = {a[6:0], c};
                nf = {f[7:6], r[5], 1'b0, r[3], f[FLAG_PV], 1'b0, a[7]};
            end
            OP_RRA: begin
                r  = {c, a[7:1]};
                nf = {f[7:6], r[5], 1'b0, r[3], f[FLAG_PV], 1'b0, a[0]};
            end
            OP_DAA: begin
                r  = daa_r;
                nf = {daa_r[7], (daa_r == 8'd0), daa_r[5], a[4] ^ daa_r[4], daa_r[3],
                      ~^daa_r, f[FLAG_N], daa_c};
            end
            OP_CPL: begin
                r  = ~a;
                nf = {f[7:6], ~a[5], 1'b1, ~a[3], f[FLAG_PV], 1'b1, c};
            end
            OP_SCF: begin
                nf = {f[7:6], a[5], 1'b0, a[3], f[FLAG_PV], 1'b0, 1'b1};
            end
            OP_CCF: begin
                nf = {f[7:6], a[5], c, a[3], f[FLAG_PV], 1'b0, ~c};
            end
            OP_NEG: begin
                r  = neg_res[7:0];
                nf = neg_res[15:8];
            end
            OP_LOADA: begin
                r = v;
            end
            OP_LOADF: begin
                nf = v;
            end
            default: begin
                r  = a;
                nf = f;
            end
        endcase
    end

    assign o_nxt.acc   = r;
    assign o_nxt.flags = nf;

endmodule

// File: hdl/z80_accumulator_flag_unit.sv
// Z80 accumulator and flag unit.
// Input channel: i_valid / o_stall carry an item (i_op, i_operand); an item
// is taken at a rising edge with i_valid high and o_stall low.
// Output channel: o_valid / i_stall carry the result (o_acc_out, o_flags_out);
// it is taken at a rising edge with o_valid high and i_stall low.
// Each item passes an input register, then the ALU logic, and its result is
// written into the accumulator and flag registers, which drive the output.
// Throughput: one item per cycle while i_stall is low, limited by the single
// accumulator/flag register that each item reads and rewrites.
// While the receiver stalls, the pending result holds and one more item is
// taken into the input register; o_stall rises only when both are full.
// Reset (synchronous, active low) clears the accumulator and flags to zero
// and empties both registers; nothing is offered at the output after reset.
module z80_accumulator_flag_unit import z80af_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [4:0] i_op,
    input  logic [7:0] i_operand,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_acc_out,
    output logic [7:0] o_flags_out
);

    logic       r_in_valid;
    logic       n_in_valid;
    logic [4:0] r_op;
    logic [7:0] r_operand;
    logic       r_out_valid;
    logic       n_out_valid;
    t_af        r_af;
    t_af        n_af;
    t_af        alu_nxt;
    logic       in_take;
    logic       advance;

    // Move an item into the state when the output slot is free or drains
    assign advance = r_in_valid && (!r_out_valid || !i_stall);
    assign o_stall = r_in_valid && !advance;
    assign in_take = i_valid && !o_stall;

    z80af_alu u_alu (
        .i_cur     (r_af),
        .i_op      (r_op),
        .i_operand (r_operand),
        .o_nxt     (alu_nxt)
    );

    // Next-state logic for both stages
    always_comb begin
        n_in_valid  = in_take || (r_in_valid && !advance);
        n_out_valid = advance || (r_out_valid && i_stall);
        n_af        = advance ? alu_nxt : r_af;
    end

    // Control and state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_af        <= '0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
            r_af        <= n_af;
        end
    end

    // Capture the item payload
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_op      <= i_op;
            r_operand <= i_operand;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_acc_out   = r_af.acc;
    assign o_flags_out = r_af.flags;

`include "z80_accumulator_flag_unit_assert.svh"

    `Z80AF_ASSERT_NEXT(a_adv_gives_out, i_clk, i_rst_n, advance, r_out_valid)
    `Z80AF_ASSERT_NEXT(a_idle_holds_state, i_clk, i_rst_n, !advance, $stable(r_af))
    `Z80AF_ASSERT_NEXT(a_loada_value, i_clk, i_rst_n,
        advance && (t_op'(r_op) == OP_LOADA), r_af.acc == $past(r_operand))
    `Z80AF_ASSERT_SAME(a_stall_full, i_clk, i_rst_n, o_stall,
        r_in_valid && r_out_valid && i_stall)

endmodule

// File: test/tb_z80_accumulator_flag_unit.sv
module tb_z80_accumulator_flag_unit import z80af_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned RAND_ITEMS  = 1100;
    localparam int unsigned CYCLE_LIMIT = 400000;

    // Op codes past the last defined one leave the state untouched
    localparam logic [4:0] OP_NOP_FIRST = 5'd19;
    localparam logic [4:0] OP_NOP_LAST  = 5'd31;

    // Flag masks built from the package bit positions
    localparam logic [7:0] M_S    = 8'h01 << FLAG_S;
    localparam logic [7:0] M_Z    = 8'h01 << FLAG_Z;
    localparam logic [7:0] M_U5   = 8'h01 << FLAG_U5;
    localparam logic [7:0] M_H    = 8'h01 << FLAG_H;
    localparam logic [7:0] M_U3   = 8'h01 << FLAG_U3;
    localparam logic [7:0] M_PV   = 8'h01 << FLAG_PV;
    localparam logic [7:0] M_N    = 8'h01 << FLAG_N;
    localparam logic [7:0] M_C    = 8'h01 << FLAG_C;
    localparam logic [7:0] M_XY   = M_U5 | M_U3;
    localparam logic [7:0] M_KEEP = M_S | M_Z | M_PV;

    typedef struct packed {
        logic [4:0] op;
        logic [7:0] operand;
        logic       typed;
        logic [7:0] acc;
        logic [7:0] flags;
    } t_row;

    // Directed items; typed rows carry their own expected acc and flags
    localparam t_row DIR_ROWS [29] = '{
        '{OP_LOADA,    8'h00, 1'b1, 8'h00, 8'h00},
        '{OP_LOADF,    8'hFF, 1'b1, 8'h00, 8'hFF},
        '{OP_LOADA,    8'hFF, 1'b1, 8'hFF, 8'hFF},
        '{OP_ADD,      8'h01, 1'b1, 8'h00, 8'h51},
        '{OP_ADC,      8'hFF, 1'b0, 8'h00, 8'h00},
        '{OP_LOADA,    8'h7F, 1'b1, 8'h7F, 8'h51},
        '{OP_ADD,      8'h01, 1'b1, 8'h80, 8'h94},
        '{OP_SUB,      8'h01, 1'b0, 8'h00, 8'h00},
        '{OP_SBC,      8'hFF, 1'b0, 8'h00, 8'h00},
        '{OP_AND,      8'h0F, 1'b0, 8'h00, 8'h00},
        '{OP_XOR,      8'hFF, 1'b0, 8'h00, 8'h00},
        '{OP_OR,       8'h00, 1'b0, 8'h00, 8'h00},
        '{OP_CP,       8'h28, 1'b0, 8'h00, 8'h00},
        '{OP_RLCA,     8'h00, 1'b0, 8'h00, 8'h00},
        '{OP_RRCA,     8'h00, 1'b0, 8'h00, 8'h00},
        '{OP_RLA,      8'h00, 1'b0, 8'h00, 8'h00},
        '{OP_RRA,      8'h00, 1'b0, 8'h00, 8'h00},
        '{OP_LOADA,    8'h9A, 1'b0, 8'h00, 8'h00},
        '{OP_DAA,      8'h00, 1'b0, 8'h00, 8'h00},
        '{OP_LOADA,    8'h15, 1'b0, 8'h00, 8'h00},
        '{OP_SUB,      8'h06, 1'b0, 8'h00, 8'h00},
        '{OP_DAA,      8'h00, 1'b0, 8'h00, 8'h00},
        '{OP_CPL,      8'h00, 1'b0, 8'h00, 8'h00},
        '{OP_SCF,      8'h00, 1'b0, 8'h00, 8'h00},
        '{OP_CCF,      8'h00, 1'b0, 8'h00, 8'h00},
        '{OP_CCF,      8'h00, 1'b0, 8'h00, 8'h00},
        '{OP_LOADA,    8'h80, 1'b0, 8'h00, 8'h00},
        '{OP_NEG,      8'h00, 1'b0, 8'h00, 8'h00},
        '{OP_NOP_LAST, 8'hFF, 1'b0, 8'h00, 8'h00}
    };

    logic       i_clk     = 1'b0;
    logic       i_rst_n   = 1'b0;
    logic       i_valid   = 1'b0;
    logic [4:0] i_op      = '0;
    logic [7:0] i_operand = '0;
    logic       i_stall   = 1'b0;
    logic       o_stall;
    logic       o_valid;
    logic [7:0] o_acc_out;
    logic [7:0] o_flags_out;

    t_af         af_model = '0;
    t_af         af_expected_q [$];
    t_af         af_head;
    int unsigned err_count  = 0;
    int unsigned cycle_cnt  = 0;
    int unsigned stall_left = 0;
    bit          item_taken = 1'b0;
    bit          burst_mode = 1'b0;
    bit          row_typed  = 1'b0;
    logic [7:0]  row_acc    = '0;
    logic [7:0]  row_flags  = '0;

    z80_accumulator_flag_unit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_op        (i_op),
        .i_operand   (i_operand),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_acc_out   (o_acc_out),
        .o_flags_out (o_flags_out)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // S, Z and the two undocumented bits of a result byte
    function automatic logic [7:0] szxy(logic [7:0] r);
        return (r & (M_S | M_XY)) | ((r == 8'h00) ? M_Z : 8'h00);
    endfunction

    function automatic logic [7:0] parity_flag(logic [7:0] r);
        return (~^r) ? M_PV : 8'h00;
    endfunction

    function automatic t_af sum_af(logic [7:0] a, logic [7:0] b, logic cin);
        logic [8:0] s;
        logic [4:0] h;
        t_af        o;
        s = {1'b0, a} + {1'b0, b} + {8'b0, cin};
        h = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'b0, cin};
        o.acc   = s[7:0];
        o.flags = szxy(s[7:0]) | (h[4] ? M_H : 8'h00)
                | (((a[7] ^ s[7]) & (b[7] ^ s[7])) ? M_PV : 8'h00) | {7'b0, s[8]};
        return o;
    endfunction

    function automatic t_af diff_af(logic [7:0] a, logic [7:0] b, logic cin);
        logic [8:0] s;
        logic [4:0] h;
        t_af        o;
        s = {1'b0, a} - {1'b0, b} - {8'b0, cin};
        h = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'b0, cin};
        o.acc   = s[7:0];
        o.flags = szxy(s[7:0]) | M_N | (h[4] ? M_H : 8'h00)
                | (((a[7] ^ b[7]) & (a[7] ^ s[7])) ? M_PV : 8'h00) | {7'b0, s[8]};
        return o;
    endfunction

    // Next accumulator and flags for one item
    function automatic t_af next_af(t_af cur, logic [4:0] op, logic [7:0] v);
        logic [7:0] a, f, r, keep, corr;
        logic       c, cout;
        t_af        res;
        a    = cur.acc;
        f    = cur.flags;
        c    = f[FLAG_C];
        keep = f & M_KEEP;
        res  = cur;
        case (op)
            OP_ADD: res = sum_af(a, v, 1'b0);
            OP_ADC: res = sum_af(a, v, c);
            OP_SUB: res = diff_af(a, v, 1'b0);
            OP_SBC: res = diff_af(a, v, c);
            OP_AND: begin
                r = a & v;
                res.acc   = r;
                res.flags = szxy(r) | M_H | parity_flag(r);
            end
            OP_XOR: begin
                r = a ^ v;
                res.acc   = r;
                res.flags = szxy(r) | parity_flag(r);
            end
            OP_OR: begin
                r = a | v;
                res.acc   = r;
                res.flags = szxy(r) | parity_flag(r);
            end
            OP_CP: begin
                // flags of the difference, but bits 5 and 3 from the operand
                res       = diff_af(a, v, 1'b0);
                res.acc   = a;
                res.flags = (res.flags & ~M_XY) | (v & M_XY);
            end
            OP_RLCA: begin
                r = {a[6:0], a[7]};
                res.acc   = r;
                res.flags = keep | (r & M_XY) | {7'b0, a[7]};
            end
            OP_RRCA: begin
                r = {a[0], a[7:1]};
                res.acc   = r;
                res.flags = keep | (r & M_XY) | {7'b0, a[0]};
            end
            OP_RLA: begin
                r = {a[6:0], c};
                res.acc   = r;
                res.flags = keep | (r & M_XY) | {7'b0, a[7]};
            end
            OP_RRA: begin
                r = {c, a[7:1]};
                res.acc   = r;
                res.flags = keep | (r & M_XY) | {7'b0, a[0]};
            end
            OP_DAA: begin
                corr = 8'h00;
                cout = c;
                if (f[FLAG_H] || (a[3:0] > DAA_NIB_MAX)) corr = corr | DAA_CORR_L;
                if (c || (a > DAA_LIMIT)) begin
                    corr = corr | DAA_CORR_H;
                    cout = 1'b1;
                end
                r = f[FLAG_N] ? (a - corr) : (a + corr);
                res.acc   = r;
                res.flags = szxy(r) | ((a ^ r) & M_H) | parity_flag(r) | (f & M_N)
                          | {7'b0, cout};
            end
            OP_CPL: begin
                r = ~a;
                res.acc   = r;
                res.flags = keep | (r & M_XY) | M_H | M_N | {7'b0, c};
            end
            OP_SCF: res.flags = keep | (a & M_XY) | M_C;
            OP_CCF: res.flags = keep | (a & M_XY) | (c ? M_H : 8'h00) | {7'b0, ~c};
            OP_NEG: res = diff_af(8'h00, a, 1'b0);
            OP_LOADA: res.acc = v;
            OP_LOADF: res.flags = v;
            default: res = cur;
        endcase
        return res;
    endfunction

    // Idle length before the next item: mostly none, sometimes short, rarely long
    function automatic int unsigned pick_gap();
        int unsigned p;
        p = $urandom_range(0, 99);
        if (burst_mode || p < 60) return 0;
        if (p < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 20);
    endfunction

    function automatic logic [7:0] pick_operand();
        if ($urandom_range(0, 99) >= 15) return 8'($urandom_range(0, 255));
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hFF;
            2: return 8'h7F;
            3: return 8'h80;
            4: return 8'h99;
            5: return 8'h9A;
            6: return 8'h0F;
            default: return 8'hF0;
        endcase
    endfunction

    // Offer one item and hold it until it is taken
    task automatic send_item(input logic [4:0] op, input logic [7:0] opd, input bit typed,
                             input logic [7:0] e_acc, input logic [7:0] e_flags);
        int unsigned gap;
        gap = pick_gap();
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid   <= 1'b1;
        i_op      <= op;
        i_operand <= opd;
        row_typed  = typed;
        row_acc    = e_acc;
        row_flags  = e_flags;
        item_taken = 1'b0;
        do @(negedge i_clk); while (!item_taken);
        item_taken = 1'b0;
    endtask

    // Stall the result side in random bursts
    always @(negedge i_clk) begin
        if (stall_left != 0) begin
            stall_left = stall_left - 1;
            i_stall <= 1'b1;
        end else if (burst_mode || $urandom_range(0, 99) < 70) begin
            i_stall <= 1'b0;
        end else begin
            stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 25)
                                                     : $urandom_range(0, 2);
            i_stall <= 1'b1;
        end
    end

    // Check taken results, then predict for a taken item
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (af_expected_q.size() == 0) begin
                    $display("%0t: result acc %02h flags %02h with nothing outstanding",
                             $time, o_acc_out, o_flags_out);
                    err_count++;
                end else begin
                    af_head = af_expected_q.pop_front();
                    if (o_acc_out !== af_head.acc) begin
                        $display("%0t: acc expected %02h actual %02h",
                                 $time, af_head.acc, o_acc_out);
                        err_count++;
                    end
                    if (o_flags_out !== af_head.flags) begin
                        $display("%0t: flags expected %02h actual %02h",
                                 $time, af_head.flags, o_flags_out);
                        err_count++;
                    end
                end
            end
            if (i_valid && !o_stall) begin
                af_model = next_af(af_model, i_op, i_operand);
                af_expected_q.push_back(row_typed ? t_af'({row_acc, row_flags}) : af_model);
                item_taken = 1'b1;
            end
        end
    end

    // Stop a hung run
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("z80_accumulator_flag_unit test failed");
            $finish;
        end
    end

    initial begin
        int unsigned k;
        logic [4:0]  op;
        logic [7:0]  bcd_a;
        logic [7:0]  bcd_b;
        int unsigned p;

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Walk the directed table
        foreach (DIR_ROWS[j])
            send_item(DIR_ROWS[j].op, DIR_ROWS[j].operand, DIR_ROWS[j].typed,
                      DIR_ROWS[j].acc, DIR_ROWS[j].flags);

        // Random items, with decimal add/subtract/adjust sequences mixed in
        k = 0;
        while (k < RAND_ITEMS) begin
            if (k % 150 < 3) burst_mode = ($urandom_range(0, 3) == 0);
            p = $urandom_range(0, 99);
            if (p < 8) begin
                bcd_a = {4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))};
                bcd_b = {4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))};
                op    = 5'($urandom_range(OP_ADD, OP_SBC));
                send_item(OP_LOADA, bcd_a, 1'b0, 8'h00, 8'h00);
                send_item(op, bcd_b, 1'b0, 8'h00, 8'h00);
                send_item(OP_DAA, pick_operand(), 1'b0, 8'h00, 8'h00);
                k = k + 3;
            end else begin
                if (p < 11)
                    op = 5'($urandom_range(OP_NOP_FIRST, OP_NOP_LAST));
                else if (p < 18)
                    op = OP_LOADF;
                else
                    op = 5'($urandom_range(OP_ADD, OP_LOADA));
                send_item(op, pick_operand(), 1'b0, 8'h00, 8'h00);
                k = k + 1;
            end
        end
        i_valid <= 1'b0;

        // Drain, then let the block idle before finishing
        while (af_expected_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);

        if (err_count == 0)
            $display("z80_accumulator_flag_unit test passed");
        else
            $display("z80_accumulator_flag_unit test failed");
        $finish;
    end

endmodule

// File: z80_accumulator_flag_unit.f
+incdir+hdl
hdl/z80af_pkg.sv
hdl/z80af_alu.sv
hdl/z80_accumulator_flag_unit.sv
test/tb_z80_accumulator_flag_unit.sv
